// ===== sv/job_order_scheduler_top_macros.svh =====
// Assertion macros used by the sequencer module.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef JOB_ORDER_SCHEDULER_TOP_MACROS_SVH
`define JOB_ORDER_SCHEDULER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jos_pkg.sv =====
package jos_pkg;

  localparam int unsigned JosMaxJobs = 32;
  localparam int unsigned CtimeW     = 21;
  localparam int unsigned TotalW     = 26;

  localparam logic       REQ_LOAD  = 1'b0;
  localparam logic       REQ_SCHED = 1'b1;

  localparam logic [1:0] POL_SJF   = 2'd1;
  localparam logic [1:0] POL_PRIO  = 2'd2;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [7:0]  id;
  } job_entry_t;

  typedef struct packed {
    logic              empty;
    logic              last;
    logic [TotalW-1:0] total;
    logic [CtimeW-1:0] ctime;
    job_entry_t        entry;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_CUR_RD,
    ST_CUR_WAIT,
    ST_ORD_RD,
    ST_ORD_WAIT,
    ST_CMP,
    ST_EM_RD,
    ST_EM_WAIT,
    ST_EM_OUT
  } seq_state_e;

  // True when job a must be sent strictly ahead of job b under the policy.
  function automatic logic goes_before(job_entry_t a, job_entry_t b, logic [1:0] pol);
    logic r;
    r = 1'b0;
    if (pol == POL_SJF) begin
      if (a.burst != b.burst) begin
        r = a.burst < b.burst;
      end else begin
        r = a.prio > b.prio;
      end
    end else if (pol == POL_PRIO) begin
      if (a.prio != b.prio) begin
        r = a.prio > b.prio;
      end else begin
        r = a.burst < b.burst;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/jos_job_store.sv =====
module jos_job_store
  import jos_pkg::*;
#(
  parameter int unsigned MaxJobs = JosMaxJobs,
  localparam int unsigned IdxW   = $clog2(MaxJobs),
  localparam int unsigned CntW   = $clog2(MaxJobs + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  job_entry_t      load_entry_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output job_entry_t      rd_data_o,
  output logic [CntW-1:0] count_o
);

  job_entry_t      mem [MaxJobs];
  job_entry_t      rd_data_q;
  logic [CntW-1:0] count_q, count_d;
  logic            wr_en;

  assign wr_en   = load_i && (count_q < CntW'(MaxJobs));
  assign count_d = wr_en ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IdxW-1:0]] <= load_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

// ===== sv/jos_out_stage.sv =====
module jos_out_stage
  import jos_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    slot_free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign slot_free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/jos_sequencer.sv =====
`include "job_order_scheduler_top_macros.svh"

module jos_sequencer
  import jos_pkg::*;
#(
  parameter int unsigned MaxJobs = JosMaxJobs,
  localparam int unsigned IdxW   = $clog2(MaxJobs),
  localparam int unsigned CntW   = $clog2(MaxJobs + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            req_type_i,
  input  logic [1:0]      policy_i,
  output logic            in_ready_o,
  input  logic [CntW-1:0] count_i,
  output logic            store_re_o,
  output logic [IdxW-1:0] store_raddr_o,
  input  job_entry_t      store_rdata_i,
  input  logic            slot_free_i,
  output logic            push_o,
  output result_t         res_o
);

  logic [IdxW-1:0] ord_mem [MaxJobs];
  logic [IdxW-1:0] ord_rdata_q;
  logic            ord_we, ord_re;
  logic [IdxW-1:0] ord_waddr, ord_wdata, ord_raddr;

  seq_state_e        state_q, state_d;
  logic [IdxW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d, od_q, od_d;
  job_entry_t        cur_q, cur_d;
  logic [1:0]        pol_q, pol_d;
  logic [CtimeW-1:0] run_q, run_d, run_sum;
  logic [TotalW-1:0] total_q, total_d, tot_sum;
  logic              i_last, k_last;

  assign i_last  = (CntW'(i_q) + CntW'(1)) == count_i;
  assign k_last  = (CntW'(k_q) + CntW'(1)) == count_i;
  assign run_sum = run_q + CtimeW'(store_rdata_i.burst);
  assign tot_sum = total_q + TotalW'(run_sum);

  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    j_d           = j_q;
    k_d           = k_q;
    od_d          = od_q;
    cur_d         = cur_q;
    pol_d         = pol_q;
    run_d         = run_q;
    total_d       = total_q;
    in_ready_o    = 1'b0;
    store_re_o    = 1'b0;
    store_raddr_o = i_q;
    ord_we        = 1'b0;
    ord_waddr     = j_q;
    ord_wdata     = i_q;
    ord_re        = 1'b0;
    ord_raddr     = k_q;
    push_o        = 1'b0;
    res_o         = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (req_type_i == REQ_SCHED)) begin
          if (count_i == '0) begin
            state_d = ST_EMPTY;
          end else begin
            pol_d   = policy_i;
            i_d     = '0;
            state_d = ST_CUR_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (slot_free_i) begin
          push_o       = 1'b1;
          res_o.empty  = 1'b1;
          res_o.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_CUR_RD: begin
        store_re_o    = 1'b1;
        store_raddr_o = i_q;
        j_d           = i_q;
        state_d       = ST_CUR_WAIT;
      end
      ST_CUR_WAIT: begin
        cur_d   = store_rdata_i;
        state_d = ST_ORD_RD;
      end
      ST_ORD_RD: begin
        if (j_q == '0) begin
          ord_we    = 1'b1;
          ord_waddr = j_q;
          ord_wdata = i_q;
          if (i_last) begin
            k_d     = '0;
            run_d   = '0;
            total_d = '0;
            state_d = ST_EM_RD;
          end else begin
            i_d     = i_q + IdxW'(1);
            state_d = ST_CUR_RD;
          end
        end else begin
          ord_re    = 1'b1;
          ord_raddr = j_q - IdxW'(1);
          state_d   = ST_ORD_WAIT;
        end
      end
      ST_ORD_WAIT: begin
        od_d          = ord_rdata_q;
        store_re_o    = 1'b1;
        store_raddr_o = ord_rdata_q;
        state_d       = ST_CMP;
      end
      ST_CMP: begin
        ord_we    = 1'b1;
        ord_waddr = j_q;
        if (goes_before(cur_q, store_rdata_i, pol_q)) begin
          ord_wdata = od_q;
          j_d       = j_q - IdxW'(1);
          state_d   = ST_ORD_RD;
        end else begin
          ord_wdata = i_q;
          if (i_last) begin
            k_d     = '0;
            run_d   = '0;
            total_d = '0;
            state_d = ST_EM_RD;
          end else begin
            i_d     = i_q + IdxW'(1);
            state_d = ST_CUR_RD;
          end
        end
      end
      ST_EM_RD: begin
        ord_re    = 1'b1;
        ord_raddr = k_q;
        state_d   = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        store_re_o    = 1'b1;
        store_raddr_o = ord_rdata_q;
        state_d       = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (slot_free_i) begin
          push_o      = 1'b1;
          res_o.entry = store_rdata_i;
          res_o.ctime = run_sum;
          res_o.last  = k_last;
          res_o.total = k_last ? tot_sum : '0;
          run_d       = run_sum;
          total_d     = tot_sum;
          if (k_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + IdxW'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      pol_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      pol_q   <= pol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q    <= od_d;
    cur_q   <= cur_d;
    run_q   <= run_d;
    total_q <= total_d;
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rdata_q <= ord_mem[ord_raddr];
    end
  end

  `JOS_ASSERT_IMP(a_push_needs_slot, push_o, slot_free_i, "word pushed into a full output slot")
  `JOS_ASSERT_IMP(a_insert_pos, (state_q == ST_ORD_RD) || (state_q == ST_CMP), j_q <= i_q, "insert position beyond current job")
  `JOS_ASSERT_IMP(a_emit_in_range, state_q == ST_EM_OUT, CntW'(k_q) < count_i, "emit index beyond job count")
  `JOS_ASSERT_NXT(a_last_to_idle, push_o && res_o.last, state_q == ST_IDLE, "run did not end after last word")

endmodule

// ===== sv/job_order_scheduler_top.sv =====
// Load word: accepted when idle, gives no output word.
// Schedule word: insertion sort over the order memory, each comparison being an
// order read, a job read, and a compare and write back; then per output word an
// order read, a job read and a sum. With no jobs stored, a single empty word.
// Reset clears the job count and control state; memory contents stay undefined.
module job_order_scheduler_top
  import jos_pkg::*;
#(
  parameter int unsigned MaxJobs = JosMaxJobs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // job_id[7:0], burst_time[23:8], priority_req[31:24], policy[33:32], zero pad
  input  logic [39:0] s_axis_tdata,
  // req_type[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_job_id[7:0], out_burst_time[23:8], out_priority[31:24],
  // completion_time[52:32], total_completion[78:53], zero pad
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // empty_res[0]
  output logic        m_axis_tuser
);

  localparam int unsigned IdxW = $clog2(MaxJobs);
  localparam int unsigned CntW = $clog2(MaxJobs + 1);

  job_entry_t      in_entry, store_rdata;
  logic            load;
  logic            store_re;
  logic [IdxW-1:0] store_raddr;
  logic [CntW-1:0] count;
  logic            slot_free, push;
  result_t         res_push, res_out;

  assign in_entry.id    = s_axis_tdata[7:0];
  assign in_entry.burst = s_axis_tdata[23:8];
  assign in_entry.prio  = s_axis_tdata[31:24];
  assign load = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD);

  jos_job_store #(.MaxJobs(MaxJobs)) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .load_entry_i (in_entry),
    .rd_en_i      (store_re),
    .rd_addr_i    (store_raddr),
    .rd_data_o    (store_rdata),
    .count_o      (count)
  );

  jos_sequencer #(.MaxJobs(MaxJobs)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .req_type_i    (s_axis_tuser),
    .policy_i      (s_axis_tdata[33:32]),
    .in_ready_o    (s_axis_tready),
    .count_i       (count),
    .store_re_o    (store_re),
    .store_raddr_o (store_raddr),
    .store_rdata_i (store_rdata),
    .slot_free_i   (slot_free),
    .push_o        (push),
    .res_o         (res_push)
  );

  jos_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_push),
    .slot_free_o (slot_free),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (res_out)
  );

  assign m_axis_tdata = {1'b0, res_out.total, res_out.ctime, res_out.entry.prio,
                         res_out.entry.burst, res_out.entry.id};
  assign m_axis_tlast = res_out.last;
  assign m_axis_tuser = res_out.empty;

endmodule

// ===== tb/job_order_scheduler_checker.sv =====
module job_order_scheduler_checker
  import jos_pkg::*;
#(
  parameter int unsigned MaxJobs = JosMaxJobs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [39:0] in_data_i,
  input  logic        in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [79:0] out_data_i,
  input  logic        out_last_i,
  input  logic        out_user_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);

  job_entry_t  jobs [MaxJobs];
  int          n_jobs;
  result_t     schedule_q [$];
  result_t     got;
  result_t     want;
  int unsigned word_no;

  // A smaller key means the job is sent earlier. Arrival order gives every job the same key.
  function automatic logic [23:0] rank_key(job_entry_t j, logic [1:0] pol);
    if (pol == POL_SJF) begin
      return {j.burst, ~j.prio};
    end
    if (pol == POL_PRIO) begin
      return {~j.prio, j.burst};
    end
    return '0;
  endfunction

  // Each job's position is the number of jobs ranked ahead of it, with equal keys
  // taken in arrival order, so the ordering is stable.
  function automatic void plan_schedule(logic [1:0] pol);
    int                slot [MaxJobs];
    logic [23:0]       key [MaxJobs];
    int                pos;
    logic [CtimeW-1:0] finish;
    logic [TotalW-1:0] sum;
    result_t           r;
    if (n_jobs == 0) begin
      r       = '0;
      r.last  = 1'b1;
      r.empty = 1'b1;
      schedule_q.push_back(r);
      return;
    end
    for (int i = 0; i < n_jobs; i++) begin
      key[i] = rank_key(jobs[i], pol);
    end
    for (int i = 0; i < n_jobs; i++) begin
      pos = 0;
      for (int j = 0; j < n_jobs; j++) begin
        if (key[j] < key[i] || (key[j] == key[i] && j < i)) begin
          pos++;
        end
      end
      slot[pos] = i;
    end
    finish = '0;
    sum    = '0;
    for (int k = 0; k < n_jobs; k++) begin
      r       = '0;
      r.entry = jobs[slot[k]];
      finish  = finish + r.entry.burst;
      sum     = sum + finish;
      r.ctime = finish;
      if (k == n_jobs - 1) begin
        r.total = sum;
        r.last  = 1'b1;
      end
      schedule_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_jobs       = 0;
      word_no      = 0;
      mismatches_o = 0;
      schedule_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (in_user_i == REQ_LOAD) begin
          if (n_jobs < MaxJobs) begin
            jobs[n_jobs] = in_data_i[31:0];
            n_jobs++;
          end
        end else begin
          plan_schedule(in_data_i[33:32]);
        end
      end
      if (out_valid_i && out_ready_i) begin
        got.entry = out_data_i[31:0];
        got.ctime = out_data_i[52:32];
        got.total = out_data_i[78:53];
        got.last  = out_last_i;
        got.empty = out_user_i;
        if (schedule_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("word %0d arrived with nothing expected: id %0d burst %0d prio %0d",
                     word_no, got.entry.id, got.entry.burst, got.entry.prio);
          end
        end else begin
          want = schedule_q.pop_front();
          if (got.entry.id !== want.entry.id || got.entry.burst !== want.entry.burst ||
              got.entry.prio !== want.entry.prio || got.ctime !== want.ctime ||
              got.total !== want.total || got.last !== want.last ||
              got.empty !== want.empty) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("word %0d expected id %0d burst %0d prio %0d ctime %0d total %0d last %0b empty %0b",
                       word_no, want.entry.id, want.entry.burst, want.entry.prio,
                       want.ctime, want.total, want.last, want.empty);
              $display("word %0d got      id %0d burst %0d prio %0d ctime %0d total %0d last %0b empty %0b",
                       word_no, got.entry.id, got.entry.burst, got.entry.prio,
                       got.ctime, got.total, got.last, got.empty);
            end
          end
        end
        word_no++;
      end
    end
    pending_o = schedule_q.size();
  end

endmodule

// ===== tb/tb_job_order_scheduler_top.sv =====
module tb_job_order_scheduler_top;
  import jos_pkg::*;

  localparam logic [1:0]  POL_ARRIVAL = 2'd0;
  localparam logic [1:0]  POL_SPARE   = 2'd3;
  localparam int unsigned RandomWords = 400;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_BUSY,
    RX_CHOKED
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned loads_sent;
  int unsigned burst_left;
  int unsigned counted;

  job_order_scheduler_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  job_order_scheduler_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_last_i   (m_axis_tlast),
    .out_user_i   (m_axis_tuser),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic offer(logic req, logic [7:0] id, logic [15:0] burst, logic [7:0] prio,
                       logic [1:0] pol);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'b0, pol, prio, burst, id};
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == REQ_LOAD) begin
      loads_sent++;
    end
  endtask

  // The first edge is always waited for, so a schedule word accepted just now is counted.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned cycles;
    int unsigned hold;
    bit          held_once;
    mode          = RX_OPEN;
    mode_left     = 0;
    cycles        = 0;
    hold          = 0;
    held_once     = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycles++;
      if (!held_once && cycles > 4000 && m_axis_tvalid && s_axis_tvalid) begin
        hold      = 400;
        held_once = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: begin
            m_axis_tready <= 1'b1;
          end
          RX_BUSY: begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic        is_load;
    logic        ignored;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [1:0]  pol;
    int unsigned pick;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_LOAD;
    loads_sent = 0;
    burst_left = 0;
    counted    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty store first, then a handful of jobs with extreme and tied fields.
    offer(REQ_SCHED, 8'hff, 16'hffff, 8'hff, POL_ARRIVAL);
    offer(REQ_SCHED, 8'h00, 16'h0000, 8'h00, POL_SPARE);
    offer(REQ_LOAD, 8'd0, 16'hffff, 8'd0, POL_SPARE);
    offer(REQ_SCHED, 8'h5a, 16'ha5a5, 8'h3c, POL_SJF);
    offer(REQ_LOAD, 8'd255, 16'd0, 8'd255, POL_PRIO);
    offer(REQ_LOAD, 8'd7, 16'hffff, 8'd255, POL_SJF);
    offer(REQ_LOAD, 8'd8, 16'd0, 8'd255, POL_ARRIVAL);
    offer(REQ_LOAD, 8'd9, 16'd300, 8'd0, POL_SPARE);
    offer(REQ_LOAD, 8'd10, 16'd300, 8'd0, POL_SPARE);
    offer(REQ_SCHED, 8'd0, 16'd0, 8'd0, POL_ARRIVAL);
    offer(REQ_SCHED, 8'hff, 16'hffff, 8'hff, POL_SJF);
    offer(REQ_SCHED, 8'd0, 16'd0, 8'd0, POL_PRIO);
    offer(REQ_SCHED, 8'hff, 16'hffff, 8'hff, POL_SPARE);
    wait_drained();

    while (counted < RandomWords) begin
      if (loads_sent < JosMaxJobs) begin
        is_load = ($urandom_range(0, 1) == 0);
      end else begin
        is_load = ($urandom_range(0, 9) == 0);
      end
      ignored = is_load && (loads_sent >= JosMaxJobs);
      id  = 8'($urandom);
      pol = 2'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        burst = 16'($urandom_range(0, 4));
      end else if (pick == 4) begin
        burst = 16'hffff;
      end else if (pick == 5) begin
        burst = 16'd0;
      end else begin
        burst = 16'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        prio = 8'($urandom_range(0, 3));
      end else if (pick == 4) begin
        prio = 8'hff;
      end else if (pick == 5) begin
        prio = 8'h00;
      end else begin
        prio = 8'($urandom);
      end
      offer(is_load ? REQ_LOAD : REQ_SCHED, id, burst, prio, pol);
      if (!ignored) begin
        counted++;
        if (counted % 100 == 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
